@@ rtl/fut_pkg.sv @@
package fut_pkg;

	localparam logic [7:0] CHR_NUL   = 8'h00;
	localparam logic [7:0] CHR_PCT   = 8'h25;
	localparam logic [7:0] CHR_PLUS  = 8'h2B;
	localparam logic [7:0] CHR_EQ    = 8'h3D;
	localparam logic [7:0] CHR_AMP   = 8'h26;
	localparam logic [7:0] CHR_SPACE = 8'h20;

	localparam int unsigned MAX_RES = 3;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       byte_valid;
		logic       in_value;
		logic       token_end;
		logic       pair_end;
		logic       string_end;
	} res_t;

	// {is_hex, nibble}
	function automatic logic [4:0] hex_nib(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, c[3:0]};
		end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
			r = {1'b1, c[3:0] + 4'd9};
		end
		return r;
	endfunction

endpackage

@@ rtl/form_urlencoded_tokenizer.sv @@
// Form string tokenizer: one raw byte per item in, decoded bytes and end markers out.
// Latency: results of an item are offered the cycle after it is accepted.
// Throughput: one item per cycle while out_ready is high and each item gives at most
// one result; an item that gives n results holds the input off until its last is taken (output drain register).
// Reset (arst_n low): awaiting a name, no escape pending, result register empty.
module form_urlencoded_tokenizer (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] data_byte,
	output logic       byte_valid,
	output logic       in_value,
	output logic       token_end,
	output logic       pair_end,
	output logic       string_end,
	output logic       last_result
);
	import fut_pkg::*;

	typedef enum logic [1:0] {
		MODE_IDLE   = 2'd0,
		MODE_NAME   = 2'd1,
		MODE_VSTART = 2'd2,
		MODE_VALUE  = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		ESC_NONE  = 2'd0,
		ESC_PCT   = 2'd1,
		ESC_DIGIT = 2'd2
	} esc_t;

	mode_t      mode_q, mode_n;
	esc_t       esc_q, esc_n;
	logic [7:0] held_q, held_n;

	res_t       res_s1 [MAX_RES];
	logic [1:0] cnt_s1;

	res_t       res_n [MAX_RES];
	logic [1:0] n_res;

	logic       in_acc, out_acc;

	function automatic res_t mk(input logic [7:0] d, input logic bv, input logic iv,
		input logic te, input logic pe, input logic se);
		res_t r;
		r.data_byte  = d;
		r.byte_valid = bv;
		r.in_value   = iv;
		r.token_end  = te;
		r.pair_end   = pe;
		r.string_end = se;
		return r;
	endfunction

	always_comb begin
		logic       do_content, do_flush, do_marker, done, inval, is_end, is_delim;
		logic [4:0] hc, hh;
		res_t       marker;
		logic [1:0] n;

		do_content = 1'b0;
		do_flush   = 1'b0;
		do_marker  = 1'b0;
		done       = 1'b0;
		inval      = 1'b0;
		marker     = '0;
		n          = 2'd0;
		mode_n     = mode_q;
		esc_n      = esc_q;
		held_n     = held_q;
		for (int i = 0; i < MAX_RES; i++) begin
			res_n[i] = '0;
		end
		is_end   = (in_byte == CHR_AMP) || (in_byte == CHR_NUL);
		is_delim = (in_byte == CHR_AMP) || (in_byte == CHR_EQ);
		hc       = hex_nib(in_byte);
		hh       = hex_nib(held_q);

		case (mode_q)
			MODE_IDLE: begin
				esc_n = ESC_NONE;
				if (in_byte == CHR_NUL) begin
					do_marker = 1'b1;
					marker    = mk(CHR_NUL, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1);
				end else if (!is_delim) begin
					mode_n     = MODE_NAME;
					do_content = 1'b1;
				end
			end
			MODE_NAME: begin
				if (in_byte == CHR_EQ) begin
					do_flush  = 1'b1;
					do_marker = 1'b1;
					marker    = mk(CHR_NUL, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0);
					mode_n    = MODE_VSTART;
				end else if (is_end) begin
					do_flush  = 1'b1;
					do_marker = 1'b1;
					marker    = mk(CHR_NUL, 1'b0, 1'b0, 1'b1, 1'b1, in_byte == CHR_NUL);
					mode_n    = MODE_IDLE;
				end else begin
					do_content = 1'b1;
				end
			end
			MODE_VSTART: begin
				esc_n = ESC_NONE;
				if (is_end) begin
					// value absent
					do_marker = 1'b1;
					marker    = mk(CHR_NUL, 1'b0, 1'b0, 1'b0, 1'b1, in_byte == CHR_NUL);
					mode_n    = MODE_IDLE;
				end else begin
					mode_n     = MODE_VALUE;
					do_content = 1'b1;
					inval      = 1'b1;
				end
			end
			default: begin
				inval = 1'b1;
				if (is_end) begin
					do_flush  = 1'b1;
					do_marker = 1'b1;
					marker    = mk(CHR_NUL, 1'b0, 1'b1, 1'b1, 1'b1, in_byte == CHR_NUL);
					mode_n    = MODE_IDLE;
				end else begin
					do_content = 1'b1;
				end
			end
		endcase

		// escape continuation; a non-hex byte breaks the escape
		if (do_content) begin
			case (esc_n)
				ESC_PCT: begin
					if (hc[4]) begin
						esc_n  = ESC_DIGIT;
						held_n = in_byte;
						done   = 1'b1;
					end else begin
						do_flush = 1'b1;
					end
				end
				ESC_DIGIT: begin
					if (hc[4]) begin
						res_n[n] = mk({hh[3:0], hc[3:0]}, 1'b1, inval, 1'b0, 1'b0, 1'b0);
						n        = n + 2'd1;
						esc_n    = ESC_NONE;
						held_n   = 8'd0;
						done     = 1'b1;
					end else begin
						do_flush = 1'b1;
					end
				end
				default: esc_n = ESC_NONE;
			endcase
		end

		// pending escape bytes go out literally
		if (do_flush) begin
			if (esc_n == ESC_PCT || esc_n == ESC_DIGIT) begin
				res_n[n] = mk(CHR_PCT, 1'b1, inval, 1'b0, 1'b0, 1'b0);
				n        = n + 2'd1;
			end
			if (esc_n == ESC_DIGIT) begin
				res_n[n] = mk(held_q, 1'b1, inval, 1'b0, 1'b0, 1'b0);
				n        = n + 2'd1;
			end
			esc_n  = ESC_NONE;
			held_n = 8'd0;
		end

		if (do_content && !done) begin
			if (in_byte == CHR_PCT) begin
				esc_n = ESC_PCT;
			end else begin
				res_n[n] = mk((in_byte == CHR_PLUS) ? CHR_SPACE : in_byte, 1'b1, inval,
					1'b0, 1'b0, 1'b0);
				n        = n + 2'd1;
			end
		end

		if (do_marker) begin
			res_n[n] = marker;
			n        = n + 2'd1;
		end

		if (mode_n == MODE_IDLE) begin
			esc_n  = ESC_NONE;
			held_n = 8'd0;
		end
		n_res = n;
	end

	assign in_ready  = (cnt_s1 == 2'd0) || (out_ready && cnt_s1 == 2'd1);
	assign in_acc    = in_valid && in_ready;
	assign out_valid = (cnt_s1 != 2'd0);
	assign out_acc   = out_valid && out_ready;

	assign data_byte   = res_s1[0].data_byte;
	assign byte_valid  = res_s1[0].byte_valid;
	assign in_value    = res_s1[0].in_value;
	assign token_end   = res_s1[0].token_end;
	assign pair_end    = res_s1[0].pair_end;
	assign string_end  = res_s1[0].string_end;
	assign last_result = (cnt_s1 == 2'd1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			esc_q  <= ESC_NONE;
			held_q <= 8'd0;
			cnt_s1 <= 2'd0;
			for (int i = 0; i < MAX_RES; i++) begin
				res_s1[i] <= '0;
			end
		end else begin
			if (in_acc) begin
				mode_q <= mode_n;
				esc_q  <= esc_n;
				held_q <= held_n;
			end
			if (in_acc && n_res != 2'd0) begin
				cnt_s1 <= n_res;
				for (int i = 0; i < MAX_RES; i++) begin
					res_s1[i] <= res_n[i];
				end
			end else if (out_acc) begin
				cnt_s1 <= cnt_s1 - 2'd1;
				for (int i = 0; i < MAX_RES - 1; i++) begin
					res_s1[i] <= res_s1[i + 1];
				end
			end
		end
	end

	a_term_resets: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && in_byte == CHR_NUL |=> mode_q == MODE_IDLE && esc_q == ESC_NONE)
		else $error("terminator did not return to idle");

	a_more_follow: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && !last_result |=> out_valid)
		else $error("results of an item lost");

	a_esc_in_token: assert property (@(posedge clk) disable iff (!arst_n)
		esc_q != ESC_NONE |-> mode_q == MODE_NAME || mode_q == MODE_VALUE)
		else $error("escape pending outside a token");

endmodule
